### design/triangle_face_normal_macros.svh
// Assertion macros shared by the triangle face normal RTL.
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

`ifndef ASSERT_OFF
`define TFN_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tfn: assertion failed");
`define TFN_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfn: implication failed");
`else
`define TFN_ASSERT(lbl, clk, rst, prop)
`define TFN_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif

`endif

### design/tfn_pkg.sv
package tfn_pkg;

  // Cross product magnitudes are brought below 2**NORM_BITS before squaring.
  localparam int NORM_BITS = 30;
  localparam int SQ_BITS = 2 * NORM_BITS;
  localparam int SUM_BITS = SQ_BITS + 2;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic degen;
    logic [2:0] neg;
    logic [2:0][SQ_BITS-1:0] sq;
    logic [SUM_BITS-1:0] sum;
  } tfn_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tfn_q_status_t;

endpackage

### design/triangle_face_normal.sv
// Triangle face unit normal: cross product of B-A and C-A scaled to unit length.
// The accepting edge reaches the done strobe through the front end, the queue and the
// bit-per-stage divider and square root pipelines.
// Throughput: one request per cycle; busy stays low while out of reset.
// Reset (rst, synchronous) clears all valid flags; requests in flight are dropped.
// done marks each result for one cycle; the receiver cannot stall.
`include "triangle_face_normal_macros.svh"

module triangle_face_normal #(
  parameter int COORD_WIDTH = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic signed [COORD_WIDTH-1:0] third_x,
  input  logic signed [COORD_WIDTH-1:0] third_y,
  input  logic signed [COORD_WIDTH-1:0] third_z,
  output logic done,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_z,
  output logic degenerate
);
  import tfn_pkg::*;

  localparam int LATENCY = 3 * NORMAL_FRAC_BITS + 12;

  logic accept;
  logic push;
  tfn_entry_t front_entry, back_entry;
  tfn_q_status_t q_status;

  assign busy = rst || q_status.full;
  assign accept = start && !busy;

  tfn_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .first_x(first_x),
    .first_y(first_y),
    .first_z(first_z),
    .second_x(second_x),
    .second_y(second_y),
    .second_z(second_z),
    .third_x(third_x),
    .third_y(third_y),
    .third_z(third_z),
    .push(push),
    .entry(front_entry)
  );

  // The back end never stalls, so it takes the head entry whenever there is one.
  tfn_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din(front_entry),
    .pop(!q_status.empty),
    .dout(back_entry),
    .status(q_status)
  );

  tfn_back #(
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .in_valid(!q_status.empty),
    .in_entry(back_entry),
    .done(done),
    .normal_x(normal_x),
    .normal_y(normal_y),
    .normal_z(normal_z),
    .degenerate(degenerate)
  );

  `TFN_ASSERT_IMP(a_latency, clk, rst, done, $past(start && !busy, LATENCY))

endmodule

### design/tfn_front.sv
module tfn_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic signed [COORD_WIDTH-1:0] third_x,
  input  logic signed [COORD_WIDTH-1:0] third_y,
  input  logic signed [COORD_WIDTH-1:0] third_z,
  output logic push,
  output tfn_pkg::tfn_entry_t entry
);
  import tfn_pkg::*;

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * EW;
  localparam int CRW = PW + 1;
  localparam int MW = 2 * COORD_WIDTH + 1;
  localparam int SHW = $clog2(MW + 1);

  logic v1, v2, v3, v4, v5;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pb [3];
  logic [2:0][MW-1:0] mag;
  logic [2:0] neg3, neg4, neg5;
  logic [2:0][NORM_BITS-1:0] amag;
  logic [2:0][SQ_BITS-1:0] sq;
  logic zero4, zero5;
  logic [MW-1:0] orv;
  logic [SHW-1:0] sh;
  logic [2:0][NORM_BITS-1:0] shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Edges B-A and C-A.
  always_ff @(posedge clk) begin
    e1[0] <= EW'(second_x) - EW'(first_x);
    e1[1] <= EW'(second_y) - EW'(first_y);
    e1[2] <= EW'(second_z) - EW'(first_z);
    e2[0] <= EW'(third_x) - EW'(first_x);
    e2[1] <= EW'(third_y) - EW'(first_y);
    e2[2] <= EW'(third_z) - EW'(first_z);
  end

  always_ff @(posedge clk) begin
    pa[0] <= e1[1] * e2[2];
    pb[0] <= e1[2] * e2[1];
    pa[1] <= e1[2] * e2[0];
    pb[1] <= e1[0] * e2[2];
    pa[2] <= e1[0] * e2[1];
    pb[2] <= e1[1] * e2[0];
  end

  always_ff @(posedge clk) begin
    logic signed [CRW-1:0] c;
    logic signed [CRW-1:0] cabs;
    for (int j = 0; j < 3; j++) begin
      c = CRW'(pa[j]) - CRW'(pb[j]);
      cabs = c[CRW-1] ? -c : c;
      neg3[j] <= c[CRW-1];
      mag[j] <= cabs[MW-1:0];
    end
  end

  // The largest magnitude has the highest set bit of the OR of all three.
  always_comb begin
    orv = mag[0] | mag[1] | mag[2];
    sh = '0;
    for (int i = NORM_BITS; i < MW; i++) begin
      if (orv[i]) sh = SHW'(i - NORM_BITS + 1);
    end
    for (int j = 0; j < 3; j++) begin
      logic [MW+NORM_BITS-1:0] wide;
      wide = {{NORM_BITS{1'b0}}, mag[j]} >> sh;
      shifted[j] = wide[NORM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    amag <= shifted;
    neg4 <= neg3;
    zero4 <= (orv == '0);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sq[j] <= amag[j] * amag[j];
    end
    neg5 <= neg4;
    zero5 <= zero4;
  end

  assign push = v5;
  assign entry.degen = zero5;
  assign entry.neg = neg5;
  assign entry.sq = sq;
  assign entry.sum = SUM_BITS'(sq[0]) + SUM_BITS'(sq[1]) + SUM_BITS'(sq[2]);

endmodule

### design/tfn_queue.sv
`include "triangle_face_normal_macros.svh"

module tfn_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tfn_pkg::tfn_entry_t din,
  input  logic pop,
  output tfn_pkg::tfn_entry_t dout,
  output tfn_pkg::tfn_q_status_t status
);
  import tfn_pkg::*;

  localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  tfn_entry_t slots [QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;
  logic do_push, do_pop;

  assign status.full = (count == CNTW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_pop = pop && !status.empty;
  assign do_push = push && (!status.full || do_pop);
  assign dout = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= din;
  end

  `TFN_ASSERT(a_no_overflow, clk, rst, !(push && status.full && !pop))

endmodule

### design/tfn_back.sv
`include "triangle_face_normal_macros.svh"

module tfn_back #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  tfn_pkg::tfn_entry_t in_entry,
  output logic done,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_z,
  output logic degenerate
);
  import tfn_pkg::*;

  localparam int F = NORMAL_FRAC_BITS;
  localparam int DIV_STEPS = 2 * F + 2;
  localparam int QW = 2 * F + 3;
  localparam int SQ_STEPS = F + 2;
  localparam int WW = 2 * SQ_STEPS;
  localparam int RTW = F + 2;
  localparam int RMW = F + 4;
  localparam int OW = F + 2;

  // Divider: W = floor(a*a * 4**(F+1) / S), one quotient bit per stage.
  logic dvld [DIV_STEPS+1];
  logic [SUM_BITS-1:0] dsum [DIV_STEPS+1];
  logic [SUM_BITS-1:0] drem [DIV_STEPS+1][3];
  logic [QW-1:0] dquo [DIV_STEPS+1][3];
  logic [2:0] dneg [DIV_STEPS+1];
  logic ddeg [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) dvld[0] <= 1'b0;
    else dvld[0] <= in_valid;
  end

  // Since a*a <= S, the integer part of the quotient is only 0 or 1.
  always_ff @(posedge clk) begin
    logic q0;
    for (int j = 0; j < 3; j++) begin
      q0 = SUM_BITS'(in_entry.sq[j]) >= in_entry.sum;
      drem[0][j] <= SUM_BITS'(in_entry.sq[j]) - (q0 ? in_entry.sum : '0);
      dquo[0][j] <= QW'(q0);
    end
    dsum[0] <= in_entry.sum;
    dneg[0] <= in_entry.neg;
    ddeg[0] <= in_entry.degen;
  end

  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [SUM_BITS:0] r2;
      logic take;
      assign r2 = {drem[i-1][j], 1'b0};
      assign take = r2 >= {1'b0, dsum[i-1]};
      always_ff @(posedge clk) begin
        drem[i][j] <= take ? SUM_BITS'(r2 - {1'b0, dsum[i-1]}) : SUM_BITS'(r2);
        dquo[i][j] <= {dquo[i-1][j][QW-2:0], take};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dvld[i] <= 1'b0;
      else dvld[i] <= dvld[i-1];
    end
    always_ff @(posedge clk) begin
      dsum[i] <= dsum[i-1];
      dneg[i] <= dneg[i-1];
      ddeg[i] <= ddeg[i-1];
    end
  end

  // Integer square root of W, two radicand bits per stage.
  logic svld [SQ_STEPS];
  logic [RTW-1:0] sroot [SQ_STEPS][3];
  logic [RMW-1:0] srem [SQ_STEPS][3];
  logic [WW-1:0] sw [SQ_STEPS][3];
  logic [2:0] sneg [SQ_STEPS];
  logic sdeg [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic vld_in;
    logic [2:0] neg_in;
    logic deg_in;
    if (k == 0) begin : g_first
      assign vld_in = dvld[DIV_STEPS];
      assign neg_in = dneg[DIV_STEPS];
      assign deg_in = ddeg[DIV_STEPS];
    end else begin : g_next
      assign vld_in = svld[k-1];
      assign neg_in = sneg[k-1];
      assign deg_in = sdeg[k-1];
    end
    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [RTW-1:0] root_in;
      logic [RMW-1:0] rem_in;
      logic [WW-1:0] w_in;
      logic [RMW+1:0] cat, trial;
      logic take;
      if (k == 0) begin : g_first
        assign root_in = '0;
        assign rem_in = '0;
        assign w_in = WW'(dquo[DIV_STEPS][j]);
      end else begin : g_next
        assign root_in = sroot[k-1][j];
        assign rem_in = srem[k-1][j];
        assign w_in = sw[k-1][j];
      end
      assign cat = {rem_in, w_in[2*(SQ_STEPS-1-k)+1 -: 2]};
      assign trial = (RMW+2)'({root_in, 2'b01});
      assign take = cat >= trial;
      always_ff @(posedge clk) begin
        sroot[k][j] <= {root_in[RTW-2:0], take};
        srem[k][j] <= take ? RMW'(cat - trial) : RMW'(cat);
        sw[k][j] <= w_in;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) svld[k] <= 1'b0;
      else svld[k] <= vld_in;
    end
    always_ff @(posedge clk) begin
      sneg[k] <= neg_in;
      sdeg[k] <= deg_in;
    end
  end

  // The answer is the largest m with (2m-1)**2 <= W, that is (isqrt(W)+1)/2.
  logic signed [OW-1:0] comp [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic [RTW:0] rp1;
      logic [F:0] m;
      rp1 = (RTW+1)'(sroot[SQ_STEPS-1][j]) + 1'b1;
      m = rp1[F+1:1];
      if (sdeg[SQ_STEPS-1]) comp[j] = '0;
      else if (sneg[SQ_STEPS-1][j]) comp[j] = -$signed(OW'(m));
      else comp[j] = $signed(OW'(m));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= svld[SQ_STEPS-1];
  end

  always_ff @(posedge clk) begin
    normal_x <= comp[0];
    normal_y <= comp[1];
    normal_z <= comp[2];
    degenerate <= sdeg[SQ_STEPS-1];
  end

  `TFN_ASSERT_IMP(a_degen_zero, clk, rst, done && degenerate,
    normal_x == '0 && normal_y == '0 && normal_z == '0)

endmodule
